[hdl/ckd_pkg.sv]
`default_nettype none
package ckd_pkg;

    localparam int HEADS_PER_CYLINDER = 15;
    localparam int TRACK_BYTES        = 65536;
    localparam int MAX_RECORDS        = 62;
    localparam int PAD_RECORDS        = 12;

    localparam logic [16:0] BLANK_DATA    = 17'd4096;
    localparam logic [16:0] HDR_BYTES     = 17'd16;
    localparam logic [16:0] REC_HDR_BYTES = 17'd8;
    localparam logic [16:0] FENCE_BYTES   = 17'd12;
    localparam logic [7:0]  FENCE_VALUE   = 8'hFF;

    typedef enum logic [2:0] {
        RK_TRACK_HDR = 3'd0,
        RK_REC_HDR   = 3'd1,
        RK_PAYLOAD   = 3'd2,
        RK_TRACK_END = 3'd3,
        RK_BLANK_REC = 3'd4,
        RK_ERROR     = 3'd5,
        RK_DONE      = 3'd6
    } result_kind_t;

    typedef enum logic [2:0] {
        PH_COUNT     = 3'd0,
        PH_KEYRUN    = 3'd1,
        PH_DATARUN   = 3'd2,
        PH_KEYBYTES  = 3'd3,
        PH_DATABYTES = 3'd4,
        PH_HALT      = 3'd5
    } phase_t;

    // Sequencer states; the first is where items are taken.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRK_HDR,
        ST_REC_ADV,
        ST_REC_RD,
        ST_REC_CHK,
        ST_PAD_HDR,
        ST_PAD_REC,
        ST_PAD_END,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic [0:0] item_kind;
        logic [7:0] stream_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] cylinder;
        logic [3:0]  head;
        logic [7:0]  record_number;
        logic [7:0]  key_length;
        logic [15:0] data_length;
        logic [7:0]  byte_value;
        logic [15:0] track_offset;
        logic [0:0]  last_of_step;
    } out_item_t;

endpackage
`default_nettype wire

[hdl/ckd_track_image_decoder.sv]
`default_nettype none
// Decodes a run-length coded count-key-data image one item at a time.
// Input channel in_valid/in_ready carries in_item: a stream byte or an
// end-of-stream mark. Output channel out_valid/out_ready carries out_item.
// The single configuration register total_cylinders is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle,
// as the block does not enforce it. Reset value is one cylinder. Run
// descriptors sit in two 64-entry synchronous RAMs (key and data).
// A payload byte is accepted and its result presented from the output
// register; a byte that closes its record also passes through ST_OUT.
// Each record header passes through three steps (advance, RAM read,
// check). A blank pad track emits 14 items. A track header is built
// in ST_TRK_HDR after the last run byte is taken, then presented from
// the output register. Results wait in the output register while out_ready
// is low and no further item is taken meanwhile.
// Reset returns the block to waiting for a record count at track zero;
// RAM contents are not cleared since every entry is written before read.
// The track index is split into cylinder and head by a running counter
// pair, so no divider is needed.
module ckd_track_image_decoder #(
    parameter int HEADS_PER_CYLINDER = ckd_pkg::HEADS_PER_CYLINDER,
    parameter int TRACK_BYTES        = ckd_pkg::TRACK_BYTES,
    parameter int MAX_RECORDS        = ckd_pkg::MAX_RECORDS,
    parameter int PAD_RECORDS        = ckd_pkg::PAD_RECORDS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ckd_pkg::in_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ckd_pkg::out_item_t     out_item,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_wdata
);

    localparam int HW = $clog2(HEADS_PER_CYLINDER + 1);
    localparam logic [17:0] TRACK_LIM = 18'(TRACK_BYTES);
    localparam logic [16:0] PAD_STRIDE = ckd_pkg::REC_HDR_BYTES + ckd_pkg::BLANK_DATA;
    localparam logic        PAD_FITS = (32'(ckd_pkg::HDR_BYTES)
        + 32'(PAD_RECORDS) * 32'(PAD_STRIDE) + 32'(ckd_pkg::FENCE_BYTES))
        <= 32'(TRACK_BYTES);

    // Memories: key run = {run, klen}, data run = {run, dlen}.
    logic [15:0] key_mem [64];
    logic [23:0] data_mem [64];
    logic        key_we, data_we;
    logic [5:0]  key_wa, data_wa, key_ra, data_ra;
    logic [15:0] key_wd, key_rd;
    logic [23:0] data_wd, data_rd;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        key_rd <= key_mem[key_ra];
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_wa] <= data_wd;
        end
        data_rd <= data_mem[data_ra];
    end

    ckd_pkg::seq_state_t st_reg, st_next;
    ckd_pkg::phase_t ph_reg, ph_next;
    logic [15:0] tcyl_reg, tcyl_next;
    logic [7:0]  rec_cnt_reg, rec_cnt_next;
    logic [6:0]  run_count_reg, run_count_next;
    logic [7:0]  run_total_reg, run_total_next;
    logic [1:0]  bif_reg, bif_next;
    logic [7:0]  run_hi_reg, run_hi_next;
    logic [7:0]  mid_reg, mid_next;
    logic [5:0]  kidx_reg, kidx_next, didx_reg, didx_next;
    logic [7:0]  kleft_reg, kleft_next, dleft_reg, dleft_next;
    logic [7:0]  cur_rec_reg, cur_rec_next;
    logic [7:0]  kbytes_reg, kbytes_next;
    logic [15:0] dbytes_reg, dbytes_next;
    logic [16:0] woff_reg, woff_next;
    logic [19:0] track_reg, track_next;
    logic [15:0] cyl_reg, cyl_next;
    logic [HW-1:0] head_reg, head_next;
    logic        first_reg, first_next;
    logic        knew_reg, knew_next, dnew_reg, dnew_next;
    logic [3:0]  pad_i_reg, pad_i_next;
    ckd_pkg::out_item_t ob_reg, ob_next;
    logic        ov_reg, ov_next;
    ckd_pkg::seq_state_t ret_reg, ret_next;

    logic [17:0] need;
    logic [7:0]  k_len;
    logic [15:0] d_len;
    logic [8:0]  tot_sum;
    logic [7:0]  tot_sat;
    logic [35:0] pad_total;

    assign in_ready  = (st_reg == ckd_pkg::ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_item  = ob_reg;

    assign k_len = key_rd[7:0];
    assign d_len = data_rd[15:0];
    assign need = 18'(woff_reg) + 18'(ckd_pkg::REC_HDR_BYTES) + 18'(k_len) + 18'(d_len)
        + 18'(ckd_pkg::FENCE_BYTES);
    assign pad_total = 36'(tcyl_reg) * 36'(HEADS_PER_CYLINDER);

    function automatic ckd_pkg::out_item_t mk(input logic [2:0] kind,
        input logic loc, input logic [15:0] cyl, input logic [3:0] hd,
        input logic [7:0] rec, input logic [7:0] kl, input logic [15:0] dl,
        input logic [7:0] val, input logic [15:0] off, input logic last);
        ckd_pkg::out_item_t r;
        r.result_kind   = kind;
        r.cylinder      = loc ? cyl : 16'd0;
        r.head          = loc ? hd : 4'd0;
        r.record_number = rec;
        r.key_length    = kl;
        r.data_length   = dl;
        r.byte_value    = val;
        r.track_offset  = loc ? off : 16'd0;
        r.last_of_step  = last;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ckd_pkg::ST_IDLE;
            ph_reg        <= ckd_pkg::PH_COUNT;
            tcyl_reg      <= 16'd1;
            rec_cnt_reg   <= '0;
            run_count_reg <= '0;
            run_total_reg <= '0;
            bif_reg       <= '0;
            run_hi_reg    <= '0;
            mid_reg       <= '0;
            kidx_reg      <= '0;
            didx_reg      <= '0;
            kleft_reg     <= '0;
            dleft_reg     <= '0;
            cur_rec_reg   <= '0;
            kbytes_reg    <= '0;
            dbytes_reg    <= '0;
            woff_reg      <= '0;
            track_reg     <= '0;
            cyl_reg       <= '0;
            head_reg      <= '0;
            first_reg     <= 1'b0;
            knew_reg      <= 1'b0;
            dnew_reg      <= 1'b0;
            pad_i_reg     <= '0;
            ov_reg        <= 1'b0;
            ret_reg       <= ckd_pkg::ST_IDLE;
        end
        else
        begin
            st_reg        <= st_next;
            ph_reg        <= ph_next;
            tcyl_reg      <= tcyl_next;
            rec_cnt_reg   <= rec_cnt_next;
            run_count_reg <= run_count_next;
            run_total_reg <= run_total_next;
            bif_reg       <= bif_next;
            run_hi_reg    <= run_hi_next;
            mid_reg       <= mid_next;
            kidx_reg      <= kidx_next;
            didx_reg      <= didx_next;
            kleft_reg     <= kleft_next;
            dleft_reg     <= dleft_next;
            cur_rec_reg   <= cur_rec_next;
            kbytes_reg    <= kbytes_next;
            dbytes_reg    <= dbytes_next;
            woff_reg      <= woff_next;
            track_reg     <= track_next;
            cyl_reg       <= cyl_next;
            head_reg      <= head_next;
            first_reg     <= first_next;
            knew_reg      <= knew_next;
            dnew_reg      <= dnew_next;
            pad_i_reg     <= pad_i_next;
            ov_reg        <= ov_next;
            ret_reg       <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
    end

    always_comb
    begin
        st_next        = st_reg;
        ph_next        = ph_reg;
        tcyl_next      = cfg_we ? cfg_wdata : tcyl_reg;
        rec_cnt_next   = rec_cnt_reg;
        run_count_next = run_count_reg;
        run_total_next = run_total_reg;
        bif_next       = bif_reg;
        run_hi_next    = run_hi_reg;
        mid_next       = mid_reg;
        kidx_next      = kidx_reg;
        didx_next      = didx_reg;
        kleft_next     = kleft_reg;
        dleft_next     = dleft_reg;
        cur_rec_next   = cur_rec_reg;
        kbytes_next    = kbytes_reg;
        dbytes_next    = dbytes_reg;
        woff_next      = woff_reg;
        track_next     = track_reg;
        cyl_next       = cyl_reg;
        head_next      = head_reg;
        first_next     = first_reg;
        knew_next      = knew_reg;
        dnew_next      = dnew_reg;
        pad_i_next     = pad_i_reg;
        ob_next        = ob_reg;
        ov_next        = ov_reg;
        ret_next       = ret_reg;
        key_we  = 1'b0;
        data_we = 1'b0;
        key_wa  = run_count_reg[5:0];
        data_wa = run_count_reg[5:0];
        key_wd  = {run_hi_reg, in_item.stream_byte};
        data_wd = {run_hi_reg, mid_reg, in_item.stream_byte};
        key_ra  = kidx_reg;
        data_ra = didx_reg;
        tot_sum = 9'(run_total_reg) + 9'(run_hi_reg);
        tot_sat = tot_sum[8] ? 8'hFF : tot_sum[7:0];

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (st_reg)
            ckd_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (in_item.item_kind == 1'b1)
                    begin
                        if (ph_reg != ckd_pkg::PH_COUNT)
                        begin
                            ob_next = mk(ckd_pkg::RK_ERROR, 1'b0, '0, '0, '0, '0,
                                '0, '0, '0, 1'b1);
                            ov_next = 1'b1;
                            ph_next = ckd_pkg::PH_HALT;
                        end
                        else if (36'(track_reg) >= pad_total)
                        begin
                            ob_next = mk(ckd_pkg::RK_DONE, 1'b0, '0, '0, '0, '0,
                                '0, '0, '0, 1'b1);
                            ov_next = 1'b1;
                        end
                        else if (!PAD_FITS)
                        begin
                            ob_next = mk(ckd_pkg::RK_ERROR, 1'b0, '0, '0, '0, '0,
                                '0, '0, '0, 1'b1);
                            ov_next = 1'b1;
                            ph_next = ckd_pkg::PH_HALT;
                        end
                        else
                        begin
                            st_next = ckd_pkg::ST_PAD_HDR;
                        end
                    end
                    else
                    begin
                        case (ph_reg)
                            ckd_pkg::PH_COUNT:
                            begin
                                if (in_item.stream_byte > 8'(MAX_RECORDS))
                                begin
                                    ob_next = mk(ckd_pkg::RK_ERROR, 1'b0, '0, '0, '0,
                                        '0, '0, '0, '0, 1'b1);
                                    ov_next = 1'b1;
                                    ph_next = ckd_pkg::PH_HALT;
                                end
                                else
                                begin
                                    rec_cnt_next   = in_item.stream_byte;
                                    run_count_next = '0;
                                    run_total_next = '0;
                                    bif_next       = '0;
                                    if (in_item.stream_byte == 8'd0)
                                    begin
                                        st_next = ckd_pkg::ST_TRK_HDR;
                                    end
                                    else
                                    begin
                                        ph_next = ckd_pkg::PH_KEYRUN;
                                    end
                                end
                            end
                            ckd_pkg::PH_KEYRUN:
                            begin
                                if (bif_reg == 2'd0)
                                begin
                                    run_hi_next = in_item.stream_byte;
                                    bif_next    = 2'd1;
                                end
                                else
                                begin
                                    bif_next = 2'd0;
                                    if (run_hi_reg != 8'd0)
                                    begin
                                        key_we = 1'b1;
                                        if (run_count_reg < 7'd64)
                                        begin
                                            run_count_next = run_count_reg + 7'd1;
                                        end
                                        run_total_next = tot_sat;
                                        if (tot_sat >= rec_cnt_reg)
                                        begin
                                            run_count_next = '0;
                                            run_total_next = '0;
                                            ph_next = ckd_pkg::PH_DATARUN;
                                        end
                                    end
                                end
                            end
                            ckd_pkg::PH_DATARUN:
                            begin
                                if (bif_reg == 2'd0)
                                begin
                                    run_hi_next = in_item.stream_byte;
                                    bif_next    = 2'd1;
                                end
                                else if (bif_reg == 2'd1)
                                begin
                                    mid_next = in_item.stream_byte;
                                    bif_next = 2'd2;
                                end
                                else
                                begin
                                    bif_next = 2'd0;
                                    if (run_hi_reg != 8'd0)
                                    begin
                                        data_we = 1'b1;
                                        if (run_count_reg < 7'd64)
                                        begin
                                            run_count_next = run_count_reg + 7'd1;
                                        end
                                        run_total_next = tot_sat;
                                        if (tot_sat >= rec_cnt_reg)
                                        begin
                                            run_count_next = '0;
                                            run_total_next = '0;
                                            st_next = ckd_pkg::ST_TRK_HDR;
                                        end
                                    end
                                end
                            end
                            ckd_pkg::PH_KEYBYTES, ckd_pkg::PH_DATABYTES:
                            begin
                                ob_next = mk(ckd_pkg::RK_PAYLOAD, 1'b1, cyl_reg,
                                    4'(head_reg), cur_rec_reg, '0, '0,
                                    in_item.stream_byte, woff_reg[15:0], 1'b0);
                                woff_next = woff_reg + 17'd1;
                                if (ph_reg == ckd_pkg::PH_KEYBYTES)
                                begin
                                    kbytes_next = kbytes_reg - 8'd1;
                                    if (kbytes_reg == 8'd1 && dbytes_reg != 16'd0)
                                    begin
                                        ph_next = ckd_pkg::PH_DATABYTES;
                                    end
                                    if (kbytes_reg == 8'd1 && dbytes_reg == 16'd0)
                                    begin
                                        first_next = 1'b0;
                                        ret_next = ckd_pkg::ST_REC_ADV;
                                    end
                                end
                                else
                                begin
                                    dbytes_next = dbytes_reg - 16'd1;
                                    if (dbytes_reg == 16'd1)
                                    begin
                                        first_next = 1'b0;
                                        ret_next = ckd_pkg::ST_REC_ADV;
                                    end
                                end
                                if (ret_next == ckd_pkg::ST_REC_ADV)
                                begin
                                    st_next = ckd_pkg::ST_OUT;
                                end
                                else
                                begin
                                    ob_next.last_of_step = 1'b1;
                                    ov_next = 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ckd_pkg::ST_TRK_HDR:
            begin
                // Start a track; also point the reads at run entry zero of both tables.
                if (!ov_reg)
                begin
                    ob_next = mk(ckd_pkg::RK_TRACK_HDR, 1'b1, cyl_reg, 4'(head_reg),
                        '0, '0, '0, '0, '0, 1'b0);
                    ov_next     = 1'b1;
                    woff_next   = ckd_pkg::HDR_BYTES;
                    cur_rec_next = '0;
                    kidx_next   = '0;
                    didx_next   = '0;
                    first_next  = 1'b1;
                    st_next     = ckd_pkg::ST_REC_ADV;
                end
            end
            ckd_pkg::ST_REC_ADV:
            begin
                if (cur_rec_reg >= rec_cnt_reg)
                begin
                    if (!ov_reg)
                    begin
                        ob_next = mk(ckd_pkg::RK_TRACK_END, 1'b1, cyl_reg, 4'(head_reg),
                            '0, '0, '0, ckd_pkg::FENCE_VALUE, woff_reg[15:0], 1'b1);
                        ov_next = 1'b1;
                        ph_next = ckd_pkg::PH_COUNT;
                        woff_next = '0;
                        track_next = track_reg + 20'd1;
                        if (head_reg == HW'(HEADS_PER_CYLINDER - 1))
                        begin
                            head_next = '0;
                            cyl_next = cyl_reg + 16'd1;
                        end
                        else
                        begin
                            head_next = head_reg + HW'(1);
                        end
                        if (track_reg == 20'hFFFFF)
                        begin
                            head_next = '0;
                            cyl_next = '0;
                        end
                        st_next = ckd_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    knew_next = first_reg;
                    dnew_next = first_reg;
                    if (!first_reg)
                    begin
                        if (kleft_reg != 8'd0)
                        begin
                            kleft_next = kleft_reg - 8'd1;
                        end
                        else
                        begin
                            kidx_next = kidx_reg + 6'd1;
                            knew_next = 1'b1;
                        end
                        if (dleft_reg != 8'd0)
                        begin
                            dleft_next = dleft_reg - 8'd1;
                        end
                        else
                        begin
                            didx_next = didx_reg + 6'd1;
                            dnew_next = 1'b1;
                        end
                    end
                    first_next = 1'b0;
                    cur_rec_next = cur_rec_reg + 8'd1;
                    st_next = ckd_pkg::ST_REC_RD;
                end
            end
            ckd_pkg::ST_REC_RD:
            begin
                // Read issued on kidx/didx this cycle; data valid next.
                st_next = ckd_pkg::ST_REC_CHK;
            end
            ckd_pkg::ST_REC_CHK:
            begin
                if (!ov_reg)
                begin
                    if (knew_reg)
                    begin
                        kleft_next = key_rd[15:8] - 8'd1;
                    end
                    if (dnew_reg)
                    begin
                        dleft_next = data_rd[23:16] - 8'd1;
                    end
                    ov_next = 1'b1;
                    if (need > TRACK_LIM)
                    begin
                        ob_next = mk(ckd_pkg::RK_ERROR, 1'b0, '0, '0, '0, '0,
                            '0, '0, '0, 1'b1);
                        ph_next = ckd_pkg::PH_HALT;
                        st_next = ckd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ob_next = mk(ckd_pkg::RK_REC_HDR, 1'b1, cyl_reg, 4'(head_reg),
                            cur_rec_reg, k_len, d_len, '0, woff_reg[15:0], 1'b0);
                        woff_next = woff_reg + ckd_pkg::REC_HDR_BYTES;
                        kbytes_next = k_len;
                        dbytes_next = d_len;
                        if (k_len != 8'd0)
                        begin
                            ph_next = ckd_pkg::PH_KEYBYTES;
                            ob_next.last_of_step = 1'b1;
                            st_next = ckd_pkg::ST_IDLE;
                        end
                        else if (d_len != 16'd0)
                        begin
                            ph_next = ckd_pkg::PH_DATABYTES;
                            ob_next.last_of_step = 1'b1;
                            st_next = ckd_pkg::ST_IDLE;
                        end
                        else
                        begin
                            st_next = ckd_pkg::ST_REC_ADV;
                        end
                    end
                end
            end
            ckd_pkg::ST_OUT:
            begin
                // Payload byte that also closes its record.
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    st_next = ret_reg;
                    ret_next = ckd_pkg::ST_IDLE;
                end
            end
            ckd_pkg::ST_PAD_HDR:
            begin
                if (!ov_reg)
                begin
                    ob_next = mk(ckd_pkg::RK_TRACK_HDR, 1'b1, cyl_reg, 4'(head_reg),
                        '0, '0, '0, '0, '0, 1'b0);
                    ov_next = 1'b1;
                    woff_next = ckd_pkg::HDR_BYTES;
                    pad_i_next = 4'd1;
                    st_next = ckd_pkg::ST_PAD_REC;
                end
            end
            ckd_pkg::ST_PAD_REC:
            begin
                if (!ov_reg)
                begin
                    ob_next = mk(ckd_pkg::RK_BLANK_REC, 1'b1, cyl_reg, 4'(head_reg),
                        8'(pad_i_reg), '0, ckd_pkg::BLANK_DATA[15:0], '0,
                        woff_reg[15:0], 1'b0);
                    ov_next = 1'b1;
                    woff_next = woff_reg + PAD_STRIDE;
                    pad_i_next = pad_i_reg + 4'd1;
                    if (pad_i_reg == 4'(PAD_RECORDS))
                    begin
                        rec_cnt_next = '0;
                        cur_rec_next = '0;
                        st_next = ckd_pkg::ST_PAD_END;
                    end
                end
            end
            ckd_pkg::ST_PAD_END:
            begin
                // Closes through the common track end path.
                st_next = ckd_pkg::ST_REC_ADV;
            end
            default:
            begin
                st_next = ckd_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ckd_pkg::ST_IDLE) |-> !in_ready)
        else $error("item taken while sequencer busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("result changed while stalled");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (ph_reg == ckd_pkg::PH_HALT) |=> (ph_reg == ckd_pkg::PH_HALT))
        else $error("left halt without reset");
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < HW'(HEADS_PER_CYLINDER))
        else $error("head counter out of range");
`endif

endmodule
`default_nettype wire
